// ===== sv/tsmga_pkg.sv =====
// tsmga_pkg: request and result transaction types and request kind codes
// for the timestamp mutex group arbiter. No dependencies.
`default_nettype none

package tsmga_pkg;

  localparam logic [1:0] KIND_CLAIM   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_SWEEP   = 2'd2;

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  group_index;
    logic [3:0]  claimant_index;
    logic [63:0] claim_stamp;
    logic [31:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic [3:0]  out_group;
    logic        held;
    logic [3:0]  holder;
    logic [63:0] holder_stamp;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/timestamp_mutex_group_arbiter_top.sv =====
// timestamp_mutex_group_arbiter_top: lease based lock manager over a claim table
// of groups by claimants, walked by one sequencer and one compare unit.
// Depends on tsmga_pkg.
//
// channel | signals                           | handshake
// request | start_i, busy_o, req_i            | taken when start_i and !busy_o
// result  | res_valid_o, res_o                | one cycle strobe, no backpressure
// config  | cfg_valid_i, cfg_ready_o, cfg_data_i | taken when valid and ready
//
// a table walk reads each entry from registered memory, then compares it
// a holder pick on one group walks every claimant of that group
// a sweep walks every group, repicks a group whose holder timed out, then publishes
// every known group; a conflict check adds a match pass over claimant pairs plus walks
// reset clears the present bits and holder state at once, no clearing pass
// results stream during publish, one per known group; the receiver cannot stall
`default_nettype none

module timestamp_mutex_group_arbiter_top #(
  parameter int NUM_GROUPS    = 16,
  parameter int NUM_CLAIMANTS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire tsmga_pkg::req_t req_i,
  output logic                 res_valid_o,
  output tsmga_pkg::res_t      res_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [31:0]     cfg_data_i
);
  import tsmga_pkg::*;

  localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CW    = $clog2(NUM_CLAIMANTS);
  localparam int DEPTH = NUM_GROUPS * NUM_CLAIMANTS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [GW-1:0] G_LAST = GW'(NUM_GROUPS - 1);
  localparam logic [CW-1:0] C_LAST = CW'(NUM_CLAIMANTS - 1);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_REL_RD   = 13'b0000000000010,
    S_REL_CHK  = 13'b0000000000100,
    S_PICK     = 13'b0000000001000,
    S_SW       = 13'b0000000010000,
    S_SW_END   = 13'b0000000100000,
    S_SW_NEXT  = 13'b0000001000000,
    S_CF_MATCH = 13'b0000010000000,
    S_CF_EARLY = 13'b0000100000000,
    S_CF_WB    = 13'b0001000000000,
    S_CF_PICK  = 13'b0010000000000,
    S_CF_PNEXT = 13'b0100000000000,
    S_PUB      = 13'b1000000000000
  } state_e;

  function automatic logic [AW-1:0] addr_of(input logic [GW-1:0] g, input logic [CW-1:0] c);
    logic [AW+GW+CW-1:0] full;
    full = (AW+GW+CW)'(g) * (AW+GW+CW)'(NUM_CLAIMANTS) + (AW+GW+CW)'(c);
    return full[AW-1:0];
  endfunction

  state_e state_q, ret_q;
  logic ph_q;
  logic [GW-1:0] g_cnt_q, pick_g_q, req_g_q;
  logic [CW-1:0] c_cnt_q, d_cnt_q, req_c_q;
  logic [63:0] req_stamp_q;
  logic [31:0] req_now_q;
  logic [31:0] timeout_q;

  logic [NUM_GROUPS-1:0][NUM_CLAIMANTS-1:0] present_q;
  logic [NUM_GROUPS-1:0] known_q, held_q, repick_q;
  logic [NUM_GROUPS-1:0][CW-1:0] hslot_q;
  logic [NUM_GROUPS-1:0][63:0] htime_q;

  logic found_q, flag_q, ef_q, rep_q;
  logic [CW-1:0] best_c_q;
  logic [63:0] best_t_q, early_q;

  logic res_valid_q;
  res_t res_q;

  // claim time and heartbeat stores
  logic [63:0] time_mem [DEPTH];
  logic [31:0] hb_mem [DEPTH];
  logic [63:0] time_rd_q;
  logic [31:0] hb_rd_q;
  logic [AW-1:0] raddr, waddr;
  logic time_we, hb_we;
  logic [63:0] time_wd;

  logic accept, req_ok;
  logic [GW-1:0] in_g;
  logic [CW-1:0] in_c;
  logic [NUM_GROUPS-1:0] set_c, set_d;
  logic match_hit, later_known;
  logic [31:0] age;

  assign accept = start_i && !busy_o;
  assign in_g   = GW'(req_i.group_index);
  assign in_c   = CW'(req_i.claimant_index);
  assign req_ok = (32'(req_i.group_index) < 32'(NUM_GROUPS)) &&
                  (32'(req_i.claimant_index) < 32'(NUM_CLAIMANTS));
  assign age    = req_now_q - hb_rd_q;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      set_c[g] = present_q[g][c_cnt_q];
      set_d[g] = present_q[g][d_cnt_q];
    end
  end

  // claimant c joins a conflict when another claimant holds the same set of two or more
  assign match_hit = (d_cnt_q != c_cnt_q) && (set_c == set_d) &&
                     ((set_c & (set_c - NUM_GROUPS'(1))) != '0);

  always_comb begin
    later_known = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (known_q[g] && (GW'(g) > g_cnt_q)) begin
        later_known = 1'b1;
      end
    end
  end

  always_comb begin
    raddr = addr_of(g_cnt_q, c_cnt_q);
    if (state_q == S_REL_RD) begin
      raddr = addr_of(req_g_q, req_c_q);
    end else if (state_q == S_PICK) begin
      raddr = addr_of(pick_g_q, c_cnt_q);
    end
  end

  always_comb begin
    waddr   = addr_of(g_cnt_q, c_cnt_q);
    time_wd = early_q;
    time_we = 1'b0;
    hb_we   = 1'b0;
    if (state_q == S_IDLE) begin
      waddr   = addr_of(in_g, in_c);
      time_wd = req_i.claim_stamp;
      if (accept && req_ok && req_i.kind == KIND_CLAIM) begin
        time_we = 1'b1;
        hb_we   = 1'b1;
      end
    end else if (state_q == S_CF_WB) begin
      time_we = present_q[g_cnt_q][c_cnt_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (time_we) begin
      time_mem[waddr] <= time_wd;
    end
    if (hb_we) begin
      hb_mem[waddr] <= req_i.now_ticks;
    end
    time_rd_q <= time_mem[raddr];
    hb_rd_q   <= hb_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      ph_q        <= 1'b0;
      g_cnt_q     <= '0;
      c_cnt_q     <= '0;
      d_cnt_q     <= '0;
      pick_g_q    <= '0;
      req_g_q     <= '0;
      req_c_q     <= '0;
      req_stamp_q <= '0;
      req_now_q   <= '0;
      timeout_q   <= TIMEOUT_RESET;
      present_q   <= '0;
      known_q     <= '0;
      held_q      <= '0;
      repick_q    <= '0;
      hslot_q     <= '0;
      htime_q     <= '0;
      found_q     <= 1'b0;
      flag_q      <= 1'b0;
      ef_q        <= 1'b0;
      rep_q       <= 1'b0;
      best_c_q    <= '0;
      best_t_q    <= '0;
      early_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_g_q     <= in_g;
            req_c_q     <= in_c;
            req_stamp_q <= req_i.claim_stamp;
            req_now_q   <= req_i.now_ticks;
            ph_q        <= 1'b0;
            g_cnt_q     <= '0;
            c_cnt_q     <= '0;
            d_cnt_q     <= '0;
            if (req_i.kind == KIND_CLAIM && req_ok) begin
              present_q[in_g][in_c] <= 1'b1;
              if (known_q[in_g] && held_q[in_g]) begin
                flag_q   <= 1'b0;
                repick_q <= '0;
                state_q  <= S_CF_MATCH;
              end else begin
                pick_g_q <= in_g;
                found_q  <= 1'b0;
                ret_q    <= S_IDLE;
                state_q  <= S_PICK;
              end
            end else if (req_i.kind == KIND_RELEASE && req_ok) begin
              state_q <= S_REL_RD;
            end else if (req_i.kind == KIND_SWEEP) begin
              rep_q   <= 1'b0;
              state_q <= S_SW;
            end
          end
        end
        S_REL_RD: begin
          state_q <= S_REL_CHK;
        end
        S_REL_CHK: begin
          if (!present_q[req_g_q][req_c_q] || time_rd_q > req_stamp_q) begin
            state_q <= S_IDLE;
          end else begin
            present_q[req_g_q][req_c_q] <= 1'b0;
            pick_g_q <= req_g_q;
            c_cnt_q  <= '0;
            ph_q     <= 1'b0;
            found_q  <= 1'b0;
            g_cnt_q  <= '0;
            ret_q    <= S_PUB;
            state_q  <= S_PICK;
          end
        end
        S_PICK: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (present_q[pick_g_q][c_cnt_q] && (!found_q || time_rd_q < best_t_q)) begin
              found_q  <= 1'b1;
              best_c_q <= c_cnt_q;
              best_t_q <= time_rd_q;
            end
            if (c_cnt_q == C_LAST) begin
              // fold in the final entry while writing the holder back
              known_q[pick_g_q] <= 1'b1;
              if (present_q[pick_g_q][c_cnt_q] && (!found_q || time_rd_q < best_t_q)) begin
                held_q[pick_g_q]  <= 1'b1;
                hslot_q[pick_g_q] <= c_cnt_q;
                htime_q[pick_g_q] <= time_rd_q;
              end else begin
                held_q[pick_g_q]  <= found_q;
                hslot_q[pick_g_q] <= found_q ? best_c_q : '0;
                htime_q[pick_g_q] <= found_q ? best_t_q : '0;
              end
              c_cnt_q <= '0;
              state_q <= ret_q;
            end else begin
              c_cnt_q <= c_cnt_q + CW'(1);
            end
          end
        end
        S_SW: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (present_q[g_cnt_q][c_cnt_q] && age > timeout_q) begin
              present_q[g_cnt_q][c_cnt_q] <= 1'b0;
              if (known_q[g_cnt_q] && held_q[g_cnt_q] && hslot_q[g_cnt_q] == c_cnt_q) begin
                rep_q <= 1'b1;
              end
            end
            if (c_cnt_q == C_LAST) begin
              c_cnt_q <= '0;
              state_q <= S_SW_END;
            end else begin
              c_cnt_q <= c_cnt_q + CW'(1);
            end
          end
        end
        S_SW_END: begin
          if (rep_q) begin
            rep_q    <= 1'b0;
            pick_g_q <= g_cnt_q;
            found_q  <= 1'b0;
            ph_q     <= 1'b0;
            ret_q    <= S_SW_NEXT;
            state_q  <= S_PICK;
          end else begin
            state_q <= S_SW_NEXT;
          end
        end
        S_SW_NEXT: begin
          c_cnt_q <= '0;
          ph_q    <= 1'b0;
          if (g_cnt_q == G_LAST) begin
            g_cnt_q <= '0;
            state_q <= S_PUB;
          end else begin
            g_cnt_q <= g_cnt_q + GW'(1);
            state_q <= S_SW;
          end
        end
        S_CF_MATCH: begin
          if (match_hit) begin
            flag_q <= 1'b1;
          end
          if (d_cnt_q == C_LAST) begin
            d_cnt_q <= '0;
            if (flag_q || match_hit) begin
              g_cnt_q <= '0;
              ph_q    <= 1'b0;
              ef_q    <= 1'b0;
              state_q <= S_CF_EARLY;
            end else if (c_cnt_q == C_LAST) begin
              g_cnt_q <= '0;
              state_q <= S_CF_PICK;
            end else begin
              c_cnt_q <= c_cnt_q + CW'(1);
            end
          end else begin
            d_cnt_q <= d_cnt_q + CW'(1);
          end
        end
        S_CF_EARLY: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (present_q[g_cnt_q][c_cnt_q] && (!ef_q || time_rd_q < early_q)) begin
              ef_q    <= 1'b1;
              early_q <= time_rd_q;
            end
            if (g_cnt_q == G_LAST) begin
              g_cnt_q <= '0;
              state_q <= S_CF_WB;
            end else begin
              g_cnt_q <= g_cnt_q + GW'(1);
            end
          end
        end
        S_CF_WB: begin
          if (g_cnt_q == G_LAST) begin
            repick_q <= repick_q | set_c;
            g_cnt_q  <= '0;
            flag_q   <= 1'b0;
            d_cnt_q  <= '0;
            if (c_cnt_q == C_LAST) begin
              state_q <= S_CF_PICK;
            end else begin
              c_cnt_q <= c_cnt_q + CW'(1);
              state_q <= S_CF_MATCH;
            end
          end else begin
            g_cnt_q <= g_cnt_q + GW'(1);
          end
        end
        S_CF_PICK: begin
          c_cnt_q <= '0;
          if (repick_q[g_cnt_q]) begin
            pick_g_q <= g_cnt_q;
            found_q  <= 1'b0;
            ph_q     <= 1'b0;
            ret_q    <= S_CF_PNEXT;
            state_q  <= S_PICK;
          end else begin
            state_q <= S_CF_PNEXT;
          end
        end
        S_CF_PNEXT: begin
          if (g_cnt_q == G_LAST) begin
            state_q <= S_IDLE;
          end else begin
            g_cnt_q <= g_cnt_q + GW'(1);
            state_q <= S_CF_PICK;
          end
        end
        S_PUB: begin
          if (known_q[g_cnt_q]) begin
            res_valid_q        <= 1'b1;
            res_q.out_group    <= 4'(g_cnt_q);
            res_q.held         <= held_q[g_cnt_q];
            res_q.holder       <= held_q[g_cnt_q] ? 4'(hslot_q[g_cnt_q]) : 4'd0;
            res_q.holder_stamp <= held_q[g_cnt_q] ? htime_q[g_cnt_q] : 64'd0;
            res_q.last         <= !later_known;
          end
          if (g_cnt_q == G_LAST) begin
            g_cnt_q <= '0;
            state_q <= S_IDLE;
          end else begin
            g_cnt_q <= g_cnt_q + GW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // the final result of a publication is never followed straight away by another
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o)
    else $error("result follows the last one of a publication");

  a_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.held) |-> (res_o.holder == 4'd0 && res_o.holder_stamp == 64'd0))
    else $error("free group reports a holder");

  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.kind == KIND_SWEEP) |=> busy_o)
    else $error("sweep transaction did not start");

endmodule

`default_nettype wire
